### sv/gsp_pkg.sv
// Package: constants, codes and types shared by the slot pool files.
`default_nettype none
package gsp_pkg;
  localparam int unsigned Slots   = 1024;
  localparam int unsigned IdxBits = 10;
  localparam int unsigned CntBits = 11;
  localparam int unsigned KeyBits = 32;
  localparam int unsigned GenBits = 8;

  localparam logic [2:0] ModeReg   = 3'd0;
  localparam logic [2:0] ModeUnreg = 3'd1;
  localparam logic [2:0] ModeGet   = 3'd2;
  localparam logic [2:0] ModeLook  = 3'd3;
  localparam logic [2:0] ModeClear = 3'd4;

  localparam logic [2:0] StOk    = 3'd0;
  localparam logic [2:0] StNull  = 3'd1;
  localparam logic [2:0] StDup   = 3'd2;
  localparam logic [2:0] StOther = 3'd3;
  localparam logic [2:0] StLimit = 3'd4;
  localparam logic [2:0] StStale = 3'd5;

  typedef logic [IdxBits-1:0] idx_t;
  typedef logic [CntBits-1:0] cnt_t;
  typedef logic [KeyBits-1:0] key_t;
  typedef logic [GenBits-1:0] gen_t;

  // Slot record: generation, active flag, key.
  typedef struct packed {
    gen_t       gen;
    logic       act;
    key_t       key;
  } slot_t;
endpackage
`default_nettype wire

### sv/gsp_slot_ram.sv
// Slot record memory: one write port, one registered read port.
`default_nettype none
module gsp_slot_ram (
  input  wire                  clk_i,
  input  wire                  we_i,
  input  wire  gsp_pkg::idx_t  waddr_i,
  input  wire  gsp_pkg::slot_t wdata_i,
  input  wire  gsp_pkg::idx_t  raddr_i,
  output gsp_pkg::slot_t       rdata_o
);
  import gsp_pkg::*;
  slot_t mem [Slots];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### sv/generational_slot_pool.sv
// Top level: generational handle pool with slot memory and free stack.
//
// Channel  Direction  Handshake          Payload
// request  in         start_i / busy_o   mode, node_key, node_has_id, handle_index/gen
// result   out        done_o strobe      status, res_index, out_gen, out_key, live_count
//
// Get/unregister: read (SRead), check and write (SCheck), then the result strobe is registered;
// a handle that fails the range check answers in the cycle after acceptance.
// Register and lookup scan slots 1..high_water-1, one read a cycle: a lookup miss answers
// when the scan ends, a new registration then allocates a slot; clear walks the same slots.
// After reset a pass over all Slots entries zeroes the slot memory; busy_o is high then.
// The result strobe lasts one cycle; the receiver cannot stall it.
`default_nettype none
module generational_slot_pool (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  output logic                 busy_o,
  input  wire  [2:0]           mode_i,
  input  wire  gsp_pkg::key_t  node_key_i,
  input  wire                  node_has_id_i,
  input  wire  gsp_pkg::idx_t  handle_index_i,
  input  wire  gsp_pkg::gen_t  handle_gen_i,
  output logic                 done_o,
  output logic [2:0]           status_o,
  output gsp_pkg::idx_t        res_index_o,
  output gsp_pkg::gen_t        out_gen_o,
  output gsp_pkg::key_t        out_key_o,
  output gsp_pkg::idx_t        live_count_o
);
  import gsp_pkg::*;

  localparam logic [2:0] SInit  = 3'd0;
  localparam logic [2:0] SIdle  = 3'd1;
  localparam logic [2:0] SRead  = 3'd2;  // slot read issued
  localparam logic [2:0] SCheck = 3'd3;  // slot data valid
  localparam logic [2:0] SScan  = 3'd4;  // key scan
  localparam logic [2:0] SAlloc = 3'd5;  // allocate after scan miss
  localparam logic [2:0] SPop   = 3'd6;  // free stack data valid
  localparam logic [2:0] SClear = 3'd7;

  logic [2:0] st_q, st_d;
  cnt_t  free_top_q, free_top_d, high_q, high_d, ptr_q, ptr_d;
  idx_t  live_q, live_d;
  logic [2:0] mode_q, mode_d;
  key_t  key_q, key_d;
  logic  hid_q, hid_d;
  idx_t  hidx_q, hidx_d;
  gen_t  hgen_q, hgen_d;
  logic  rd_pend_q, rd_pend_d;   // a scan or clear read is in flight
  idx_t  rd_idx_q, rd_idx_d;
  idx_t  slot_q, slot_d;

  logic  done_q, done_d;
  logic [2:0] status_q, status_d;
  idx_t  oidx_q, oidx_d;
  gen_t  ogen_q, ogen_d;
  key_t  okey_q, okey_d;

  logic  s_we;
  idx_t  s_waddr, s_raddr;
  slot_t s_wdata, s_rdata;

  gsp_slot_ram u_ram (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  // Free stack memory
  idx_t fs_mem [Slots];
  logic fs_we;
  idx_t fs_waddr, fs_wdata, fs_raddr, fs_rdata;
  always_ff @(posedge clk_i) begin
    if (fs_we) fs_mem[fs_waddr] <= fs_wdata;
    fs_rdata <= fs_mem[fs_raddr];
  end

  gen_t gen_inc;
  assign gen_inc = (s_rdata.gen + gen_t'(1) == '0) ? gen_t'(1) : s_rdata.gen + gen_t'(1);

  always_comb begin
    st_d = st_q; free_top_d = free_top_q; high_d = high_q; ptr_d = ptr_q;
    live_d = live_q; mode_d = mode_q; key_d = key_q; hid_d = hid_q;
    hidx_d = hidx_q; hgen_d = hgen_q; rd_pend_d = 1'b0; rd_idx_d = rd_idx_q;
    slot_d = slot_q;
    done_d = 1'b0; status_d = status_q; oidx_d = oidx_q; ogen_d = ogen_q;
    okey_d = okey_q;
    s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_raddr = hidx_q;
    fs_we = 1'b0; fs_waddr = '0; fs_wdata = '0;
    fs_raddr = idx_t'(free_top_q - cnt_t'(1));
    case (st_q)
      SInit: begin
        s_we = 1'b1; s_waddr = ptr_q[IdxBits-1:0];
        ptr_d = ptr_q + cnt_t'(1);
        if (ptr_q == cnt_t'(Slots - 1)) st_d = SIdle;
      end
      SIdle: begin
        if (start_i) begin
          mode_d = mode_i; key_d = node_key_i; hid_d = node_has_id_i;
          hidx_d = handle_index_i; hgen_d = handle_gen_i;
          status_d = StStale; oidx_d = '0; ogen_d = '0; okey_d = '0;
          ptr_d = cnt_t'(1);
          case (mode_i)
            ModeUnreg, ModeGet: begin
              if (handle_gen_i == '0 || handle_index_i == '0 ||
                  cnt_t'(handle_index_i) >= high_q) begin
                done_d = 1'b1;
              end else begin
                s_raddr = handle_index_i; st_d = SRead;
              end
            end
            ModeReg, ModeLook: begin
              if (node_key_i == '0) begin
                status_d = StNull; done_d = 1'b1;
              end else begin
                st_d = SScan;
              end
            end
            ModeClear: begin
              free_top_d = '0; st_d = SClear;
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      SRead: st_d = SCheck;
      SCheck: begin
        st_d = SIdle; done_d = 1'b1;
        if (s_rdata.act && s_rdata.gen == hgen_q) begin
          status_d = StOk; oidx_d = hidx_q; ogen_d = s_rdata.gen;
          okey_d = s_rdata.key;
          if (mode_q == ModeUnreg) begin
            s_we = 1'b1; s_waddr = hidx_q; s_wdata = s_rdata; s_wdata.act = 1'b0;
            if (live_q != '0) live_d = live_q - idx_t'(1);
            fs_we = 1'b1; fs_waddr = free_top_q[IdxBits-1:0]; fs_wdata = hidx_q;
            if (free_top_q < cnt_t'(Slots)) free_top_d = free_top_q + cnt_t'(1);
          end
        end
      end
      SScan: begin
        // issue one read per cycle, check the previous one
        if (rd_pend_q && s_rdata.act && s_rdata.key == key_q) begin
          st_d = SIdle; done_d = 1'b1;
          status_d = (mode_q == ModeReg) ? StDup : StOk;
          oidx_d = rd_idx_q; ogen_d = s_rdata.gen;
        end else if (ptr_q < high_q) begin
          s_raddr = ptr_q[IdxBits-1:0]; rd_idx_d = ptr_q[IdxBits-1:0];
          rd_pend_d = 1'b1; ptr_d = ptr_q + cnt_t'(1);
        end else if (mode_q == ModeLook) begin
          st_d = SIdle; done_d = 1'b1;
        end else if (hid_q) begin
          status_d = StOther; st_d = SIdle; done_d = 1'b1;
        end else begin
          st_d = SAlloc;
        end
      end
      SAlloc: begin
        if (free_top_q != '0) begin
          free_top_d = free_top_q - cnt_t'(1); st_d = SPop;
        end else if (high_q < cnt_t'(Slots)) begin
          slot_d = high_q[IdxBits-1:0]; s_raddr = high_q[IdxBits-1:0];
          high_d = high_q + cnt_t'(1); st_d = SRead;
          mode_d = ModeClear;  // marks allocation in SRead/SCheck path
        end else begin
          status_d = StLimit; st_d = SIdle; done_d = 1'b1;
        end
      end
      SPop: begin
        slot_d = fs_rdata; s_raddr = fs_rdata;
        mode_d = ModeClear; st_d = SRead;
      end
      SClear: begin
        if (ptr_q < high_q) begin
          s_raddr = ptr_q[IdxBits-1:0]; rd_idx_d = ptr_q[IdxBits-1:0];
          rd_pend_d = 1'b1;
          fs_we = 1'b1; fs_waddr = free_top_q[IdxBits-1:0];
          fs_wdata = ptr_q[IdxBits-1:0];
          free_top_d = free_top_q + cnt_t'(1); ptr_d = ptr_q + cnt_t'(1);
        end
        if (rd_pend_q) begin
          s_we = 1'b1; s_waddr = rd_idx_q; s_wdata = s_rdata; s_wdata.act = 1'b0;
        end
        if (!(ptr_q < high_q) && !rd_pend_q) begin
          live_d = '0; status_d = StOk; st_d = SIdle; done_d = 1'b1;
        end
      end
      default: st_d = SIdle;
    endcase
    // allocation completes: mode was retagged, read slot data is valid
    if (st_q == SCheck && mode_q == ModeClear) begin
      s_we = 1'b1; s_waddr = slot_q;
      s_wdata.gen = gen_inc; s_wdata.act = 1'b1; s_wdata.key = key_q;
      fs_we = 1'b0; free_top_d = free_top_q;
      live_d = live_q + idx_t'(1);
      status_d = StOk; oidx_d = slot_q; ogen_d = gen_inc; okey_d = '0;
    end
    if (st_q == SRead && mode_q == ModeClear) s_raddr = slot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SInit; free_top_q <= '0; high_q <= cnt_t'(1); ptr_q <= '0;
      live_q <= '0; rd_pend_q <= 1'b0; done_q <= 1'b0; mode_q <= ModeReg;
    end else begin
      st_q <= st_d; free_top_q <= free_top_d; high_q <= high_d; ptr_q <= ptr_d;
      live_q <= live_d; rd_pend_q <= rd_pend_d; done_q <= done_d; mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_d_reg: begin
      key_q <= key_d; hid_q <= hid_d; hidx_q <= hidx_d; hgen_q <= hgen_d;
      rd_idx_q <= rd_idx_d; slot_q <= slot_d; status_q <= status_d;
      oidx_q <= oidx_d; ogen_q <= ogen_d; okey_q <= okey_d;
    end
  end

  assign busy_o       = (st_q != SIdle);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign res_index_o  = oidx_q;
  assign out_gen_o    = ogen_q;
  assign out_key_o    = okey_q;
  assign live_count_o = live_q;

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_top_q < high_q) else $error("free stack deeper than used slots");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> st_q == SIdle) else $error("result while still working");
  a_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_t'(live_q) < high_q) else $error("live count beyond used slots");
endmodule
`default_nettype wire

### dv/testbench.sv
// Testbench for the generational slot pool: self-predicting scoreboard, directed corners and random traffic.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import gsp_pkg::*;

  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned NumItems   = 580;

  typedef struct {
    logic [2:0] status;
    idx_t       index;
    gen_t       gen;
    key_t       key;
    idx_t       live;
  } answer_t;

  // Shadow of the slot pool; predicts one answer per accepted request.
  class pool_scoreboard;
    gen_t    gen_q[Slots];
    bit      act_q[Slots];
    key_t    key_q[Slots];
    idx_t    stack_q[Slots];
    int      top_q;
    int      hw_q;
    int      live_q;
    answer_t pending_q[$];
    int      errors;
    int      answered;
    int      st_seen[8];

    function void clear_state();
      for (int i = 0; i < Slots; i++) begin
        gen_q[i] = '0;
        act_q[i] = 1'b0;
      end
      top_q = 0;
      hw_q = 1;
      live_q = 0;
      errors = 0;
      answered = 0;
    endfunction

    function int find_key(key_t k);
      for (int i = 1; i < hw_q; i++)
        if (act_q[i] && key_q[i] == k) return i;
      return 0;
    endfunction

    function int check_handle(idx_t idx, gen_t g);
      if (g == 0 || idx == 0 || idx >= hw_q) return 0;
      if (!act_q[idx] || gen_q[idx] != g) return 0;
      return idx;
    endfunction

    function void note_request(logic [2:0] mode, key_t k, bit has_id, idx_t idx, gen_t g);
      answer_t a;
      int s;
      gen_t ng;
      a.status = StStale;
      a.index = '0;
      a.gen = '0;
      a.key = '0;
      case (mode)
        ModeReg: begin
          if (k == 0) a.status = StNull;
          else if ((s = find_key(k)) != 0) begin
            a.status = StDup;
            a.index = idx_t'(s);
            a.gen = gen_q[s];
          end else if (has_id) a.status = StOther;
          else begin
            s = 0;
            if (top_q > 0) begin
              top_q--;
              s = stack_q[top_q];
            end else if (hw_q < Slots) begin
              s = hw_q;
              hw_q++;
            end
            if (s == 0) a.status = StLimit;
            else begin
              ng = gen_q[s] + 1'b1;
              if (ng == 0) ng = gen_t'(1);
              gen_q[s] = ng;
              key_q[s] = k;
              act_q[s] = 1'b1;
              live_q++;
              a.status = StOk;
              a.index = idx_t'(s);
              a.gen = ng;
            end
          end
        end
        ModeUnreg: begin
          s = check_handle(idx, g);
          if (s != 0) begin
            a.key = key_q[s];
            act_q[s] = 1'b0;
            if (live_q > 0) live_q--;
            if (top_q < Slots) begin
              stack_q[top_q] = idx_t'(s);
              top_q++;
            end
            a.status = StOk;
            a.index = idx_t'(s);
            a.gen = gen_q[s];
          end
        end
        ModeGet: begin
          s = check_handle(idx, g);
          if (s != 0) begin
            a.status = StOk;
            a.index = idx_t'(s);
            a.gen = gen_q[s];
            a.key = key_q[s];
          end
        end
        ModeLook: begin
          if (k == 0) a.status = StNull;
          else if ((s = find_key(k)) != 0) begin
            a.status = StOk;
            a.index = idx_t'(s);
            a.gen = gen_q[s];
          end
        end
        ModeClear: begin
          top_q = 0;
          for (int i = 1; i < hw_q; i++) begin
            act_q[i] = 1'b0;
            stack_q[top_q] = idx_t'(i);
            top_q++;
          end
          live_q = 0;
          a.status = StOk;
        end
        default: ;
      endcase
      a.live = idx_t'(live_q);
      pending_q.push_back(a);
    endfunction

    function void check_answer(answer_t got);
      answer_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d idx=%0d", $time, got.status, got.index);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      answered++;
      st_seen[got.status]++;
      if (got.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.index !== e.index) begin
        $display("%0t: res_index expected %0d actual %0d", $time, e.index, got.index);
        errors++;
      end
      if (got.gen !== e.gen) begin
        $display("%0t: out_gen expected %0d actual %0d", $time, e.gen, got.gen);
        errors++;
      end
      if (got.key !== e.key) begin
        $display("%0t: out_key expected %h actual %h", $time, e.key, got.key);
        errors++;
      end
      if (got.live !== e.live) begin
        $display("%0t: live_count expected %0d actual %0d", $time, e.live, got.live);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start_i;
  logic [2:0] mode_i;
  key_t       node_key_i;
  logic       node_has_id_i;
  idx_t       handle_index_i;
  gen_t       handle_gen_i;
  wire        busy_o, done_o;
  wire  [2:0] status_o;
  idx_t       res_index_o, live_count_o;
  gen_t       out_gen_o;
  key_t       out_key_o;

  pool_scoreboard sb;
  int unsigned    idle_cycles;
  int             sent;
  key_t           key_pool[16];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  generational_slot_pool u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .mode_i, .node_key_i, .node_has_id_i,
    .handle_index_i, .handle_gen_i, .done_o, .status_o, .res_index_o, .out_gen_o,
    .out_key_o, .live_count_o
  );

  // Result monitor and watchdog.
  always @(posedge clk_i) begin
    answer_t got;
    if (rst_ni) begin
      if (done_o) begin
        got.status = status_o;
        got.index = res_index_o;
        got.gen = out_gen_o;
        got.key = out_key_o;
        got.live = live_count_o;
        sb.check_answer(got);
      end
      if (done_o || (start_i && !busy_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("%0t: watchdog expired, %0d results pending", $time, sb.pending_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One transaction: optional idle gap, then hold start until accepted.
  task automatic send(logic [2:0] mode, key_t k, bit has_id, idx_t idx, gen_t g);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    mode_i <= mode;
    node_key_i <= k;
    node_has_id_i <= has_id;
    handle_index_i <= idx;
    handle_gen_i <= g;
    do @(posedge clk_i); while (busy_o);
    sb.note_request(mode, k, has_id, idx, g);
    sent++;
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic int live_slot();
    int s;
    for (int t = 0; t < 8; t++) begin
      s = $urandom_range(1, (sb.hw_q > 1) ? sb.hw_q - 1 : 1);
      if (sb.act_q[s]) return s;
    end
    return 0;
  endfunction

  task automatic handle_op(logic [2:0] mode, bit stale);
    int s;
    gen_t g;
    s = live_slot();
    g = sb.gen_q[s];
    if (stale || s == 0) begin
      if ($urandom_range(0, 1)) g = g + gen_t'($urandom_range(1, 255));
      else s = $urandom_range(0, 1023);
    end
    send(mode, $urandom, 1'($urandom_range(0, 1)), idx_t'(s), g);
  endtask

  initial begin
    int r, s;
    sb = new();
    sb.clear_state();
    idle_cycles = 0;
    sent = 0;
    rst_ni = 1'b0;
    start_i <= 1'b0;
    mode_i <= ModeReg;
    node_key_i <= '0;
    node_has_id_i <= 1'b0;
    handle_index_i <= '0;
    handle_gen_i <= '0;
    foreach (key_pool[i]) key_pool[i] = $urandom | 32'h1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed corners.
    send(ModeClear, '0, 1'b0, '0, '0);
    send(ModeLook, '0, 1'b0, '0, '0);
    send(ModeReg, '0, 1'b0, '0, '0);
    send(ModeReg, 32'hFFFF_FFFF, 1'b0, '0, '0);
    send(ModeReg, 32'hFFFF_FFFF, 1'b1, '0, '0);
    send(ModeReg, 32'h0000_0001, 1'b1, '0, '0);
    send(ModeReg, 32'h0000_0001, 1'b0, '0, '0);
    send(ModeGet, '0, 1'b0, 10'd1, 8'd1);
    send(ModeGet, '0, 1'b0, 10'd1, 8'd0);
    send(ModeGet, '0, 1'b0, 10'd0, 8'd1);
    send(ModeGet, '0, 1'b0, 10'd1, 8'd255);
    send(ModeGet, '0, 1'b0, 10'd1023, 8'd1);
    send(ModeLook, 32'h0000_0001, 1'b0, '0, '0);
    send(ModeLook, 32'h8000_0000, 1'b0, '0, '0);
    send(ModeUnreg, '0, 1'b0, 10'd1, 8'd1);
    send(ModeUnreg, '0, 1'b0, 10'd1, 8'd1);
    send(3'd5, 32'h0000_0001, 1'b0, 10'd2, 8'd1);
    send(3'd6, '0, 1'b1, 10'd2, 8'd1);
    send(3'd7, 32'hFFFF_FFFF, 1'b1, 10'h3FF, 8'hFF);
    send(ModeClear, '0, 1'b0, '0, '0);
    send(ModeReg, 32'h0000_0002, 1'b0, '0, '0);
    send(ModeReg, 32'h0000_0002, 1'b1, '0, '0);

    // Random traffic, with one long register/unregister churn on a single
    // slot so its generation wraps past zero.
    while (sent < NumItems) begin
      if (sent == 60) begin
        for (int i = 0; i < 256; i++) begin
          send(ModeReg, 32'hC000_0000 + i, 1'b0, idx_t'($urandom), gen_t'($urandom));
          s = sb.pending_q[$].index;
          send(ModeUnreg, $urandom, 1'($urandom_range(0, 1)), idx_t'(s), sb.gen_q[s]);
        end
        wait_drained();
      end
      r = $urandom_range(0, 99);
      if (r < 5)
        send(3'($urandom_range(0, 7)), $urandom, 1'($urandom_range(0, 1)),
             idx_t'($urandom), gen_t'($urandom));
      else if (r < 40)
        send(ModeReg, key_pool[$urandom_range(0, 15)], $urandom_range(0, 9) == 0,
             idx_t'($urandom), gen_t'($urandom));
      else if (r < 65) handle_op(ModeUnreg, 1'b0);
      else if (r < 80) handle_op(ModeGet, 1'b0);
      else if (r < 90)
        send(ModeLook, key_pool[$urandom_range(0, 15)], 1'($urandom_range(0, 1)),
             idx_t'($urandom), gen_t'($urandom));
      else if (r < 97) handle_op($urandom_range(0, 1) ? ModeGet : ModeUnreg, 1'b1);
      else send(ModeClear, $urandom, 1'($urandom_range(0, 1)),
                idx_t'($urandom), gen_t'($urandom));
    end

    // Sender holds off until the pool has answered everything.
    wait_drained();
    send(ModeClear, '0, 1'b0, '0, '0);

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Requests sent: %0d, answers checked: %0d, mismatches: %0d",
             sent, sb.answered, sb.errors);
    $display("Status mix ok/null/dup/other/limit/stale: %0d/%0d/%0d/%0d/%0d/%0d",
             sb.st_seen[0], sb.st_seen[1], sb.st_seen[2], sb.st_seen[3],
             sb.st_seen[4], sb.st_seen[5]);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
